// File: sv/aisfe_pkg.sv
// ----------------------------------------------------------------------------
// aisfe_pkg
// Types and constants shared by the slot frame encoder modules.
// ----------------------------------------------------------------------------
package aisfe_pkg;

  localparam int          APB_AW            = 4;
  localparam int          RES_MAX           = 32;
  localparam int          RES_AW            = 5;

  localparam logic [15:0] CRC_POLY          = 16'h1021;
  localparam logic [15:0] CRC_SEED          = 16'hFFFF;
  localparam logic [2:0]  STUFF_LIMIT       = 3'd5;

  localparam logic [7:0]  TRAIN_PATTERN_RST = 8'h55;
  localparam logic [2:0]  TRAIN_COUNT_RST   = 3'd3;
  localparam logic [2:0]  TRAIN_COUNT_MAX   = 3'd4;
  localparam logic [7:0]  FLAG_PATTERN_RST  = 8'h7E;

  localparam logic [1:0]  REG_TRAIN_PATTERN = 2'd0;
  localparam logic [1:0]  REG_TRAIN_COUNT   = 2'd1;
  localparam logic [1:0]  REG_FLAG_PATTERN  = 2'd2;

  // one line bit from the framer to the line coder
  typedef struct packed {
    logic valid;
    logic lbit;
    logic nrzi;
  } line_bit_t;

  // one completed slot byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eos;
  } byte_ev_t;

endpackage

// File: sv/ais_slot_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// ais_slot_frame_encoder_top
// Builds a transmit slot of SLOT_BITS NRZI-coded bits from payload bytes.
//
// Input channel (in_*): one payload byte per transfer with first/last marks.
// Output channel (out_*): slot bytes, earliest bit in the MSB; end_of_slot
// marks the byte that completes the slot, overflow flags dropped frame bits.
// APB port: training pattern at 0x0, training count at 0x4, flag at 0x8.
// The framer places one line bit per cycle; a byte sends its 8 data bits
// and any stuffed zeros, then closes the step, and its results are read
// from the result buffer (up to 32 per byte, at most one per cycle).
// A first byte also sends the ramp, the training patterns and the start flag;
// a last byte also sends the CRC, the end flag and padding up to the slot end.
// Results of a byte are buffered and released when the byte is finished;
// the next byte is taken once every result has been read into the output
// register. A stalled receiver holds the output register and the buffer.
// Reset restores the default registers and starts with slot bit zero.
// ----------------------------------------------------------------------------
module ais_slot_frame_encoder_top
  import aisfe_pkg::*;
#(
  parameter int SLOT_BITS = 256,
  parameter int RAMP_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_slot_byte,
  output logic              out_end_of_slot,
  output logic              out_overflow
);

  logic [7:0]      tp_r,       tp_nxt;
  logic [2:0]      tc_r,       tc_nxt;
  logic [7:0]      fp_r,       fp_nxt;
  logic [RES_AW:0] wcnt_r,     wcnt_nxt;
  logic [RES_AW:0] rd_idx_r,   rd_idx_nxt;
  logic            drain_r,    drain_nxt;
  logic            out_vld_r,  out_vld_nxt;
  logic            step_ovf_r, step_ovf_nxt;
  logic            out_ovf_r,  out_ovf_nxt;

  logic            apb_wr;
  logic            start;
  logic            framer_idle;
  logic            step_done;
  logic            slot_clr;
  logic            slot_full;
  logic            overflow;
  line_bit_t       lb;
  byte_ev_t        ev;
  logic            wr_en;
  logic            rd_issue;
  logic [8:0]      rd_data;

  assign pready   = 1'b1;
  assign apb_wr   = psel && penable && pwrite && pready;
  assign in_ready = framer_idle && !drain_r;
  assign start    = in_valid && in_ready;

  always_comb begin
    tp_nxt = tp_r;
    tc_nxt = tc_r;
    fp_nxt = fp_r;
    if (apb_wr) begin
      unique case (paddr[3:2])
        REG_TRAIN_PATTERN: tp_nxt = pwdata[7:0];
        REG_TRAIN_COUNT:   tc_nxt = pwdata[2:0];
        REG_FLAG_PATTERN:  fp_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TRAIN_PATTERN: prdata = {24'h0, tp_r};
      REG_TRAIN_COUNT:   prdata = {29'h0, tc_r};
      REG_FLAG_PATTERN:  prdata = {24'h0, fp_r};
      default:           prdata = '0;
    endcase
  end

  aisfe_framer #(
    .RAMP_BITS (RAMP_BITS)
  ) u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .payload       (in_payload_byte),
    .first         (in_first_byte),
    .last          (in_last_byte),
    .train_pattern (tp_r),
    .train_count   (tc_r),
    .flag_pattern  (fp_r),
    .slot_full     (slot_full),
    .idle          (framer_idle),
    .step_done     (step_done),
    .slot_clr      (slot_clr),
    .lb            (lb)
  );

  aisfe_line_coder #(
    .SLOT_BITS (SLOT_BITS)
  ) u_line_coder (
    .clk       (clk),
    .rst_n     (rst_n),
    .slot_clr  (slot_clr),
    .lb        (lb),
    .ev        (ev),
    .slot_full (slot_full),
    .overflow  (overflow)
  );

  // hold results of the current byte, drop those beyond the buffer depth
  always_comb begin
    wr_en        = ev.valid && !wcnt_r[RES_AW];
    rd_issue     = drain_r && (rd_idx_r != wcnt_r) && (!out_vld_r || out_ready);
    wcnt_nxt     = wcnt_r + {{RES_AW{1'b0}}, wr_en};
    rd_idx_nxt   = rd_idx_r;
    drain_nxt    = drain_r;
    step_ovf_nxt = step_ovf_r;
    if (step_done) begin
      drain_nxt    = 1'b1;
      step_ovf_nxt = overflow;
    end
    if (drain_r && (rd_idx_r == wcnt_r)) begin
      drain_nxt  = 1'b0;
      rd_idx_nxt = '0;
      wcnt_nxt   = '0;
    end else if (rd_issue) begin
      rd_idx_nxt = rd_idx_r + (RES_AW + 1)'(1);
    end
    out_vld_nxt = rd_issue ? 1'b1 : (out_vld_r && !out_ready);
    out_ovf_nxt = rd_issue ? step_ovf_r : out_ovf_r;
  end

  aisfe_ram #(
    .WIDTH (9),
    .DEPTH (RES_MAX)
  ) u_res_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wcnt_r[RES_AW-1:0]),
    .wr_data ({ev.eos, ev.data}),
    .rd_en   (rd_issue),
    .rd_addr (rd_idx_r[RES_AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r       <= TRAIN_PATTERN_RST;
      tc_r       <= TRAIN_COUNT_RST;
      fp_r       <= FLAG_PATTERN_RST;
      wcnt_r     <= '0;
      rd_idx_r   <= '0;
      drain_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      step_ovf_r <= 1'b0;
      out_ovf_r  <= 1'b0;
    end else begin
      tp_r       <= tp_nxt;
      tc_r       <= tc_nxt;
      fp_r       <= fp_nxt;
      wcnt_r     <= wcnt_nxt;
      rd_idx_r   <= rd_idx_nxt;
      drain_r    <= drain_nxt;
      out_vld_r  <= out_vld_nxt;
      step_ovf_r <= step_ovf_nxt;
      out_ovf_r  <= out_ovf_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_slot_byte   = rd_data[7:0];
  assign out_end_of_slot = rd_data[8];
  assign out_overflow    = out_ovf_r;

  a_rd_le_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_idx_r <= wcnt_r) && (wcnt_r <= (RES_AW + 1)'(RES_MAX)))
    else $error("result buffer read index ahead of write count");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("input taken again before byte finished");

  a_drain_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_done |=> drain_r)
    else $error("byte finished without result release");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid |-> !drain_r)
    else $error("slot byte produced while results are released");

endmodule

// File: sv/aisfe_ram.sv
// ----------------------------------------------------------------------------
// aisfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aisfe_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/aisfe_line_coder.sv
// ----------------------------------------------------------------------------
// aisfe_line_coder
// NRZI coding, MSB-first byte packing and slot bit accounting.
// ----------------------------------------------------------------------------
module aisfe_line_coder
  import aisfe_pkg::*;
#(
  parameter int SLOT_BITS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      slot_clr,
  input  line_bit_t lb,
  output byte_ev_t  ev,
  output logic      slot_full,
  output logic      overflow
);

  localparam int SLOT_W = $clog2(SLOT_BITS + 1);

  logic              lvl_r,  lvl_nxt;
  logic [7:0]        sh_r,   sh_nxt;
  logic [2:0]        cnt_r,  cnt_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              ovf_r,  ovf_nxt;
  byte_ev_t          ev_r,   ev_nxt;
  logic              lvl_new;
  logic              line;
  logic [7:0]        sh_new;
  logic              eos;

  assign slot_full = (slot_r == SLOT_W'(SLOT_BITS));

  always_comb begin
    lvl_nxt      = lvl_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    slot_nxt     = slot_r;
    ovf_nxt      = ovf_r;
    ev_nxt       = ev_r;
    ev_nxt.valid = 1'b0;
    lvl_new      = lb.nrzi ? (lb.lbit ? lvl_r : ~lvl_r) : lvl_r;
    line         = lb.nrzi ? lvl_new : lb.lbit;
    sh_new       = {sh_r[6:0], line};
    eos          = (slot_r == SLOT_W'(SLOT_BITS - 1));
    if (slot_clr) begin
      lvl_nxt  = 1'b0;
      cnt_nxt  = '0;
      slot_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (lb.valid) begin
      lvl_nxt = lvl_new;
      if (slot_full) begin
        ovf_nxt = 1'b1;
      end else begin
        sh_nxt   = sh_new;
        slot_nxt = slot_r + SLOT_W'(1);
        if (cnt_r == 3'd7 || eos) begin
          ev_nxt.valid = 1'b1;
          ev_nxt.data  = sh_new << (3'd7 - cnt_r);
          ev_nxt.eos   = eos;
          cnt_nxt      = '0;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r  <= 1'b0;
      cnt_r  <= '0;
      slot_r <= '0;
      ovf_r  <= 1'b0;
      ev_r   <= '0;
    end else begin
      lvl_r  <= lvl_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
      ovf_r  <= ovf_nxt;
      ev_r   <= ev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign ev       = ev_r;
  assign overflow = ovf_r;

endmodule

// File: sv/aisfe_framer.sv
// ----------------------------------------------------------------------------
// aisfe_framer
// Frame sequencer: ramp, training, flags, payload, CRC and padding, one bit
// per cycle from a 16-bit shift register, with zero stuffing and CRC-16.
// ----------------------------------------------------------------------------
module aisfe_framer
  import aisfe_pkg::*;
#(
  parameter int RAMP_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] payload,
  input  logic       first,
  input  logic       last,
  input  logic [7:0] train_pattern,
  input  logic [2:0] train_count,
  input  logic [7:0] flag_pattern,
  input  logic       slot_full,
  output logic       idle,
  output logic       step_done,
  output logic       slot_clr,
  output line_bit_t  lb
);

  localparam int CNT_MAX   = (RAMP_BITS > 16) ? RAMP_BITS : 16;
  localparam int CNT_W     = $clog2(CNT_MAX);
  localparam int RAMP_LAST = (RAMP_BITS > 0) ? RAMP_BITS - 1 : 0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAMP, ST_TRAIN, ST_SFLAG, ST_DATA, ST_CRC, ST_EFLAG, ST_PAD, ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  state_t           hdr_state;
  logic [15:0]      sh_r,    sh_nxt;
  logic [15:0]      hdr_sh;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [2:0]       tcnt_r,  tcnt_nxt;
  logic [2:0]       ones_r,  ones_nxt;
  logic             stuff_r, stuff_nxt;
  logic             end_r,   end_nxt;
  logic             last_r,  last_nxt;
  logic [7:0]       pay_r,   pay_nxt;
  logic [15:0]      crc_r,   crc_nxt;
  logic [7:0]       pay_rev;
  logic [2:0]       tc_sat;
  logic             fb;
  logic             phase_end;

  assign idle = (state_r == ST_IDLE);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pay_rev[i] = payload[7-i];
    end
    tc_sat    = (train_count > TRAIN_COUNT_MAX) ? TRAIN_COUNT_MAX : train_count;
    hdr_state = (tc_sat != 3'd0) ? ST_TRAIN : ST_SFLAG;
    hdr_sh    = (tc_sat != 3'd0) ? {train_pattern, 8'h00} : {flag_pattern, 8'h00};
    fb        = crc_r[15] ^ sh_r[15];

    state_nxt = state_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    tcnt_nxt  = tcnt_r;
    ones_nxt  = ones_r;
    stuff_nxt = stuff_r;
    end_nxt   = end_r;
    last_nxt  = last_r;
    pay_nxt   = pay_r;
    crc_nxt   = crc_r;
    lb        = '0;
    slot_clr  = 1'b0;
    step_done = 1'b0;
    phase_end = 1'b0;

    unique case (state_r) inside
      ST_IDLE: begin
        if (start) begin
          pay_nxt  = pay_rev;
          last_nxt = last;
          cnt_nxt  = '0;
          if (first) begin
            slot_clr  = 1'b1;
            crc_nxt   = CRC_SEED;
            ones_nxt  = '0;
            stuff_nxt = 1'b0;
            end_nxt   = 1'b0;
            tcnt_nxt  = '0;
            if (RAMP_BITS > 0) begin
              state_nxt = ST_RAMP;
            end else begin
              state_nxt = hdr_state;
              sh_nxt    = hdr_sh;
            end
          end else begin
            sh_nxt    = {pay_rev, 8'h00};
            state_nxt = ST_DATA;
          end
        end
      end
      ST_RAMP: begin
        lb.valid = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(RAMP_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = hdr_state;
          sh_nxt    = hdr_sh;
        end
      end
      ST_TRAIN, ST_SFLAG, ST_EFLAG: begin
        lb.valid = 1'b1;
        lb.nrzi  = 1'b1;
        lb.lbit  = sh_r[15];
        sh_nxt   = {sh_r[14:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(7)) begin
          cnt_nxt = '0;
          if (state_r == ST_TRAIN) begin
            tcnt_nxt = tcnt_r + 3'd1;
            if ((tcnt_r + 3'd1) == tc_sat) begin
              state_nxt = ST_SFLAG;
              sh_nxt    = {flag_pattern, 8'h00};
            end else begin
              sh_nxt = {train_pattern, 8'h00};
            end
          end else if (state_r == ST_SFLAG) begin
            state_nxt = ST_DATA;
            sh_nxt    = {pay_r, 8'h00};
          end else begin
            state_nxt = ST_PAD;
            crc_nxt   = CRC_SEED;
          end
        end
      end
      ST_DATA, ST_CRC: begin
        lb.valid = 1'b1;
        lb.nrzi  = 1'b1;
        lb.lbit  = stuff_r ? 1'b0 : sh_r[15];
        if (stuff_r) begin
          stuff_nxt = 1'b0;
          end_nxt   = 1'b0;
          phase_end = end_r;
        end else begin
          sh_nxt  = {sh_r[14:0], 1'b0};
          cnt_nxt = cnt_r + CNT_W'(1);
          if (state_r == ST_DATA) begin
            crc_nxt = {crc_r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
          end
          if (sh_r[15]) begin
            if (ones_r == STUFF_LIMIT - 3'd1) begin
              ones_nxt  = '0;
              stuff_nxt = 1'b1;
            end else begin
              ones_nxt = ones_r + 3'd1;
            end
          end else begin
            ones_nxt = '0;
          end
          if (cnt_r == ((state_r == ST_DATA) ? CNT_W'(7) : CNT_W'(15))) begin
            if (stuff_nxt) begin
              end_nxt = 1'b1;
            end else begin
              phase_end = 1'b1;
            end
          end
        end
        if (phase_end) begin
          cnt_nxt = '0;
          if (state_r == ST_CRC) begin
            ones_nxt  = '0;
            sh_nxt    = {flag_pattern, 8'h00};
            state_nxt = ST_EFLAG;
          end else if (last_r) begin
            sh_nxt    = ~crc_nxt;
            state_nxt = ST_CRC;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PAD: begin
        if (slot_full) begin
          state_nxt = ST_DONE;
        end else begin
          lb.valid = 1'b1;
          lb.nrzi  = 1'b1;
        end
      end
      ST_DONE: begin
        step_done = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sh_r    <= '0;
      cnt_r   <= '0;
      tcnt_r  <= '0;
      ones_r  <= '0;
      stuff_r <= 1'b0;
      end_r   <= 1'b0;
      last_r  <= 1'b0;
      pay_r   <= '0;
      crc_r   <= CRC_SEED;
    end else begin
      state_r <= state_nxt;
      sh_r    <= sh_nxt;
      cnt_r   <= cnt_nxt;
      tcnt_r  <= tcnt_nxt;
      ones_r  <= ones_nxt;
      stuff_r <= stuff_nxt;
      end_r   <= end_nxt;
      last_r  <= last_nxt;
      pay_r   <= pay_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule
